[src/box_drawing_char_merge_macros.svh]
// ----------------------------------------------------------------------------
// Box drawing merge assertion macros
// Shared property macros for the merge block.
// ----------------------------------------------------------------------------
`ifndef BOX_DRAWING_CHAR_MERGE_MACROS_SVH
`define BOX_DRAWING_CHAR_MERGE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BDM_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BDM_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

[src/bdm_pkg.sv]
// ----------------------------------------------------------------------------
// Box drawing merge package
// Edge description table and lookup functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package bdm_pkg;
    localparam logic [15:0] BOX_BASE  = 16'h2500;
    localparam int          BOX_COUNT = 128;
    localparam logic [15:0] SPACE_CODE = 16'h0020;

    typedef logic [8:0] t_desc;

    typedef struct packed {
        logic       found;
        logic [6:0] idx;
    } t_find;

    function automatic t_desc d(input int u, input int r, input int dn, input int l,
                                input int c);
        t_desc v;
        v = t_desc'(u | (r << 2) | (dn << 4) | (l << 6) | (c << 8));
        return v;
    endfunction

    function automatic t_desc box_desc(input logic [6:0] i);
        t_desc v;
        case (i)
            7'd0: v = d(0,1,0,1,0); 7'd1: v = d(0,2,0,2,0);
            7'd2: v = d(1,0,1,0,0); 7'd3: v = d(2,0,2,0,0);
            7'd12: v = d(0,1,1,0,0); 7'd13: v = d(0,2,1,0,0);
            7'd14: v = d(0,1,2,0,0); 7'd15: v = d(0,2,2,0,0);
            7'd16: v = d(0,0,1,1,0); 7'd17: v = d(0,0,1,2,0);
            7'd18: v = d(0,0,2,1,0); 7'd19: v = d(0,0,2,2,0);
            7'd20: v = d(1,1,0,0,0); 7'd21: v = d(1,2,0,0,0);
            7'd22: v = d(2,1,0,0,0); 7'd23: v = d(2,2,0,0,0);
            7'd24: v = d(1,0,0,1,0); 7'd25: v = d(1,0,0,2,0);
            7'd26: v = d(2,0,0,1,0); 7'd27: v = d(2,0,0,2,0);
            7'd28: v = d(1,1,1,0,0); 7'd29: v = d(1,2,1,0,0);
            7'd30: v = d(2,1,1,0,0); 7'd31: v = d(1,1,2,0,0);
            7'd32: v = d(2,1,2,0,0); 7'd33: v = d(2,2,1,0,0);
            7'd34: v = d(1,2,2,0,0); 7'd35: v = d(2,2,2,0,0);
            7'd36: v = d(1,0,1,1,0); 7'd37: v = d(1,0,1,2,0);
            7'd38: v = d(2,0,1,1,0); 7'd39: v = d(1,0,2,1,0);
            7'd40: v = d(2,0,2,1,0); 7'd41: v = d(2,0,1,2,0);
            7'd42: v = d(1,0,2,2,0); 7'd43: v = d(2,0,2,2,0);
            7'd44: v = d(0,1,1,1,0); 7'd45: v = d(0,1,1,2,0);
            7'd46: v = d(0,2,1,1,0); 7'd47: v = d(0,2,1,2,0);
            7'd48: v = d(0,1,2,1,0); 7'd49: v = d(0,1,2,2,0);
            7'd50: v = d(0,2,2,1,0); 7'd51: v = d(0,2,2,2,0);
            7'd52: v = d(1,1,0,1,0); 7'd53: v = d(1,1,0,2,0);
            7'd54: v = d(1,2,0,1,0); 7'd55: v = d(1,2,0,2,0);
            7'd56: v = d(2,1,0,1,0); 7'd57: v = d(2,1,0,2,0);
            7'd58: v = d(2,2,0,1,0); 7'd59: v = d(2,2,0,2,0);
            7'd60: v = d(1,1,1,1,0); 7'd61: v = d(1,1,1,2,0);
            7'd62: v = d(1,2,1,1,0); 7'd63: v = d(1,2,1,2,0);
            7'd64: v = d(2,1,1,1,0); 7'd65: v = d(1,1,2,1,0);
            7'd66: v = d(2,1,2,1,0); 7'd67: v = d(2,1,1,2,0);
            7'd68: v = d(2,2,1,1,0); 7'd69: v = d(1,1,2,2,0);
            7'd70: v = d(1,2,2,1,0); 7'd71: v = d(2,2,1,2,0);
            7'd72: v = d(1,2,2,2,0); 7'd73: v = d(2,1,2,2,0);
            7'd74: v = d(2,2,2,1,0); 7'd75: v = d(2,2,2,2,0);
            7'd76: v = d(0,1,0,1,1); 7'd77: v = d(0,2,0,2,1);
            7'd78: v = d(1,0,1,0,1); 7'd79: v = d(2,0,2,0,1);
            7'd80: v = d(0,3,0,3,0); 7'd81: v = d(3,0,3,0,0);
            7'd82: v = d(0,3,1,0,0); 7'd83: v = d(0,1,3,0,0);
            7'd84: v = d(0,3,3,0,0); 7'd85: v = d(0,0,1,3,0);
            7'd86: v = d(0,0,3,1,0); 7'd87: v = d(0,0,3,3,0);
            7'd88: v = d(1,3,0,0,0); 7'd89: v = d(3,1,0,0,0);
            7'd90: v = d(3,3,0,0,0); 7'd91: v = d(1,0,0,3,0);
            7'd92: v = d(3,0,0,1,0); 7'd93: v = d(3,0,0,3,0);
            7'd94: v = d(1,3,1,0,0); 7'd95: v = d(3,1,3,0,0);
            7'd96: v = d(3,3,3,0,0); 7'd97: v = d(1,0,1,3,0);
            7'd98: v = d(3,0,3,1,0); 7'd99: v = d(3,0,3,3,0);
            7'd100: v = d(0,3,1,3,0); 7'd101: v = d(0,1,3,1,0);
            7'd102: v = d(0,3,3,3,0); 7'd103: v = d(1,3,0,3,0);
            7'd104: v = d(3,1,0,1,0); 7'd105: v = d(3,3,0,3,0);
            7'd106: v = d(1,3,1,3,0); 7'd107: v = d(3,1,3,1,0);
            7'd108: v = d(3,3,3,3,0); 7'd109: v = d(0,1,1,0,1);
            7'd110: v = d(0,0,1,1,1); 7'd111: v = d(1,0,0,1,1);
            7'd112: v = d(1,1,0,0,1);
            7'd116: v = d(0,0,0,1,0); 7'd117: v = d(1,0,0,0,0);
            7'd118: v = d(0,1,0,0,0); 7'd119: v = d(0,0,1,0,0);
            7'd120: v = d(0,0,0,1,0); 7'd121: v = d(1,0,0,0,0);
            7'd122: v = d(0,1,0,0,0); 7'd123: v = d(0,0,1,0,0);
            7'd124: v = d(0,2,0,1,0); 7'd125: v = d(1,0,2,0,0);
            7'd126: v = d(0,1,0,2,0); 7'd127: v = d(2,0,1,0,0);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_find find_code(input t_desc x);
        t_find f;
        f = '0;
        if (x[7:0] != 8'd0) begin
            for (int i = 0; i < BOX_COUNT; i++) begin
                if (box_desc(7'(i)) == x) begin
                    f.found = 1'b1;
                    f.idx   = 7'(i);
                end
            end
        end
        return f;
    endfunction
endpackage

[src/bdm_edges.sv]
// ----------------------------------------------------------------------------
// Box drawing merge edge stage
// Decodes the five cells and fills empty centre edges from neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bdm_edges
    import bdm_pkg::*;
(
    input  logic [15:0] i_center_char,
    input  logic        i_center_merge,
    input  logic [15:0] i_left_char,
    input  logic        i_left_merge,
    input  logic [15:0] i_right_char,
    input  logic        i_right_merge,
    input  logic [15:0] i_upper_char,
    input  logic        i_upper_merge,
    input  logic [15:0] i_lower_char,
    input  logic        i_lower_merge,
    output logic        o_elig,
    output t_desc       o_desc
);
    function automatic t_desc cell_desc(input logic [15:0] c, input logic m);
        t_desc v;
        v = '0;
        if (m && c[15:7] == BOX_BASE[15:7]) v = box_desc(c[6:0]);
        return v;
    endfunction

    t_desc x, l, r, u, dn;

    always_comb begin
        o_elig = i_center_merge && (i_center_char[15:7] == BOX_BASE[15:7]);
        x  = cell_desc(i_center_char, i_center_merge);
        l  = cell_desc(i_left_char, i_left_merge);
        r  = cell_desc(i_right_char, i_right_merge);
        u  = cell_desc(i_upper_char, i_upper_merge);
        dn = cell_desc(i_lower_char, i_lower_merge);
        if (x[7:6] == 2'd0) x[7:6] = l[3:2];
        if (x[3:2] == 2'd0) x[3:2] = r[7:6];
        if (x[1:0] == 2'd0) x[1:0] = u[5:4];
        if (x[5:4] == 2'd0) x[5:4] = dn[1:0];
        o_desc = x;
    end
endmodule

[src/box_drawing_char_merge.sv]
// Path: input transaction to the input register, then to the result register.
// Throughput: one transaction per cycle while the output is not stalled; edge fill sits before the input
// register and the table searches sit before the result register.
// Reset: i_rst_n synchronous, clears both valid flags; no other state.
// ----------------------------------------------------------------------------
// Box drawing merge top level
// Joins one cell with its four neighbors into a box drawing character or a space, else passes it on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "box_drawing_char_merge_macros.svh"
module box_drawing_char_merge
    import bdm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_center_char,
    input  logic        i_center_merge,
    input  logic [15:0] i_left_char,
    input  logic        i_left_merge,
    input  logic [15:0] i_right_char,
    input  logic        i_right_merge,
    input  logic [15:0] i_upper_char,
    input  logic        i_upper_merge,
    input  logic [15:0] i_lower_char,
    input  logic        i_lower_merge,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_merged_char
);
    logic        elig;
    t_desc       desc;
    logic        r_s1_valid, r_s1_elig;
    t_desc       r_s1_desc;
    logic [15:0] r_s1_char;
    logic        r_out_valid;
    logic [15:0] r_out_char, n_out_char;
    logic        s1_adv;
    t_desc       x, y, z, zc;
    t_find       f0, f1, f2, f3;
    logic [2:0]  n;
    logic [1:0]  least;

    bdm_edges u_edges (
        .i_center_char (i_center_char),
        .i_center_merge(i_center_merge),
        .i_left_char   (i_left_char),
        .i_left_merge  (i_left_merge),
        .i_right_char  (i_right_char),
        .i_right_merge (i_right_merge),
        .i_upper_char  (i_upper_char),
        .i_upper_merge (i_upper_merge),
        .i_lower_char  (i_lower_char),
        .i_lower_merge (i_lower_merge),
        .o_elig        (elig),
        .o_desc        (desc)
    );

    assign s1_adv  = !r_out_valid || i_ready;
    assign o_ready = !r_s1_valid || s1_adv;

    always_comb begin
        x = r_s1_desc;
        n = '0;
        least = 2'd3;
        for (int k = 0; k < 4; k++) begin
            if (x[2*k +: 2] != 2'd0) begin
                n = n + 3'd1;
                if (x[2*k +: 2] < least) least = x[2*k +: 2];
            end
        end
        if (n != 3'd2) x[8] = 1'b0;
        y = x;
        z = x;
        for (int k = 0; k < 4; k++) begin
            if (y[2*k +: 2] == 2'd2) y[2*k +: 2] = 2'd1;
            if (z[2*k +: 2] != 2'd0) z[2*k +: 2] = least;
        end
        zc = z;
        zc[8] = 1'b0;
        f0 = find_code(x);
        f1 = find_code(y);
        f2 = find_code(z);
        f3 = find_code(zc);
        if (!r_s1_elig)    n_out_char = r_s1_char;
        else if (n == 3'd0) n_out_char = SPACE_CODE;
        else if (f0.found) n_out_char = BOX_BASE | {9'd0, f0.idx};
        else if (f1.found) n_out_char = BOX_BASE | {9'd0, f1.idx};
        else if (f2.found) n_out_char = BOX_BASE | {9'd0, f2.idx};
        else if (f3.found) n_out_char = BOX_BASE | {9'd0, f3.idx};
        else               n_out_char = r_s1_char;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) r_s1_valid <= i_valid;
            if (s1_adv)  r_out_valid <= r_s1_valid;
        end
        if (o_ready && i_valid) begin
            r_s1_elig <= elig;
            r_s1_desc <= desc;
            r_s1_char <= i_center_char;
        end
        if (s1_adv && r_s1_valid) r_out_char <= n_out_char;
    end

    assign o_valid       = r_out_valid;
    assign o_merged_char = r_out_char;

    `BDM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_merged_char))
    `BDM_ASSERT_NEXT(a_flow, i_clk, i_rst_n, r_s1_valid && s1_adv, o_valid)
    `BDM_ASSERT_IMP(a_ready, i_clk, i_rst_n, !r_s1_valid, o_ready)
endmodule
